[hdl/eotp_pkg.sv]
// Package for the EDNS(0) option TLV parser: result kinds, result word type
// and queue sizing constants. No dependencies.
`default_nettype none
package eotp_pkg;

  // Header is code (2 bytes) then length (2 bytes), both big-endian
  localparam int unsigned HDR_BYTES = 4;

  // Output queue depth, a power of two, at least two words of headroom
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  // One result word
  typedef struct packed {
    kind_t       kind;
    logic [15:0] option_code;
    logic [15:0] option_length;
    logic [7:0]  byte_value;
    logic [15:0] byte_offset;
    logic        run_last;
  } result_t;

  // Results produced by one accepted input byte, compacted: res0 first
  typedef struct packed {
    logic [1:0] push_cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage
`default_nettype wire

[hdl/edns_option_tlv_parser_unit.sv]
// Top level of the EDNS(0) option TLV parser: byte stream in, tagged result
// words out. Depends on eotp_pkg, eotp_parser, eotp_out_queue.
// Result words are registered in the output queue before they are offered.
// Throughput: one input byte per cycle while the downstream takes one word
// per cycle; a byte that ends an option makes two words, drained by the
// four-word output queue, which stalls input when fewer than two slots are free.
// Reset: synchronous active-low rst_n returns to the header phase, empties the queue.
`default_nettype none
module edns_option_tlv_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // final_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [15:0] option_code, [31:16] option_length,
                                       // [39:32] byte_value, [55:40] byte_offset
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // run_last
);
  import eotp_pkg::*;

  push_t   push;
  result_t word;
  logic    room2;
  logic    byte_acc;

  assign in_tready = room2;
  assign byte_acc  = in_tvalid && room2;

  eotp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (byte_acc),
    .data_byte  (in_tdata),
    .final_byte (in_tlast),
    .push       (push)
  );

  eotp_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room2    (room2),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_word (word)
  );

  // Output word packing
  assign out_tdata = {word.byte_offset, word.byte_value, word.option_length,
                      word.option_code};
  assign out_tuser = word.kind;
  assign out_tlast = word.run_last;

endmodule
`default_nettype wire

[hdl/eotp_parser.sv]
// Option header / data state tracking for the EDNS(0) TLV parser.
// Produces up to two result words per accepted byte. Depends on eotp_pkg.
`default_nettype none
module eotp_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           byte_acc,
  input  wire logic [7:0]     data_byte,
  input  wire logic           final_byte,
  output eotp_pkg::push_t     push
);
  import eotp_pkg::*;

  logic        in_payload_r, in_payload_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [15:0] code_r, code_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] cnt_inc;

  assign cnt_inc = cnt_r + 16'd1;

  // Next state and results for the byte on the input
  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_idx_nxt    = hdr_idx_r;
    code_nxt       = code_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    push           = '0;

    if (!in_payload_r) begin
      unique case (hdr_idx_r)
        2'd0: code_nxt = {data_byte, 8'h00};
        2'd1: code_nxt = code_r | {8'h00, data_byte};
        2'd2: len_nxt  = {data_byte, 8'h00};
        2'd3: len_nxt  = len_r | {8'h00, data_byte};
        default: code_nxt = code_r;
      endcase
    end

    push.res0.option_code   = code_nxt;
    push.res0.option_length = len_nxt;
    push.res1.option_code   = code_nxt;
    push.res1.option_length = len_nxt;
    push.res0.kind          = KIND_DONE;
    push.res1.kind          = KIND_DONE;

    if (!in_payload_r) begin
      if (hdr_idx_r == 2'(HDR_BYTES - 1)) begin
        hdr_idx_nxt = 2'd0;
        if (len_nxt == 16'd0) begin
          // empty option completes on its last header byte
          push.push_cnt      = 2'd1;
          push.res0.kind     = KIND_DONE;
          push.res0.run_last = 1'b1;
        end else if (final_byte) begin
          push.push_cnt      = 2'd1;
          push.res0.kind     = KIND_DROP;
          push.res0.run_last = 1'b1;
        end else begin
          in_payload_nxt = 1'b1;
          cnt_nxt        = 16'd0;
        end
      end else begin
        hdr_idx_nxt = hdr_idx_r + 2'd1;
      end
    end else begin
      // data byte, maybe followed by a completion or drop word
      push.res0.kind        = KIND_DATA;
      push.res0.byte_value  = data_byte;
      push.res0.byte_offset = cnt_r;
      cnt_nxt               = cnt_inc;
      if (cnt_inc == len_r) begin
        push.push_cnt      = 2'd2;
        push.res1.kind     = KIND_DONE;
        push.res1.run_last = 1'b1;
        in_payload_nxt     = 1'b0;
        cnt_nxt            = 16'd0;
      end else if (final_byte) begin
        push.push_cnt      = 2'd2;
        push.res1.kind     = KIND_DROP;
        push.res1.run_last = 1'b1;
      end else begin
        push.push_cnt      = 2'd1;
        push.res0.run_last = 1'b1;
      end
    end

    // last byte of the input: back to the start
    if (final_byte) begin
      in_payload_nxt = 1'b0;
      hdr_idx_nxt    = 2'd0;
      code_nxt       = 16'd0;
      len_nxt        = 16'd0;
      cnt_nxt        = 16'd0;
    end

    if (!byte_acc) begin
      push.push_cnt = 2'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_idx_r    <= 2'd0;
      code_r       <= 16'd0;
      len_r        <= 16'd0;
      cnt_r        <= 16'd0;
    end else if (byte_acc) begin
      in_payload_r <= in_payload_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      code_r       <= code_nxt;
      len_r        <= len_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/eotp_out_queue.sv]
// Small result queue: takes up to two words per cycle, emits one word per
// cycle while out_rdy is high. Depends on eotp_pkg.
`default_nettype none
module eotp_out_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  eotp_pkg::push_t        push,
  output logic                   room2,
  output logic                   out_vld,
  input  wire logic              out_rdy,
  output eotp_pkg::result_t      out_word
);
  import eotp_pkg::*;

  result_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr1;
  logic [QCNT_W-1:0]   cnt_r;
  logic                pop;

  assign wr_ptr1  = wr_ptr_r + QPTR_W'(1);
  assign pop      = out_vld && out_rdy;
  assign out_vld  = (cnt_r != '0);
  assign out_word = mem_r[rd_ptr_r];
  // accept a byte only when both of its possible words fit
  assign room2    = (cnt_r <= QCNT_W'(QDEPTH - 2));

  // Storage
  always_ff @(posedge clk) begin
    if (push.push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.push_cnt == 2'd2) begin
      mem_r[wr_ptr1] <= push.res1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push.push_cnt) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire
